@@ src/ccte_pkg.sv @@
// Package: shared types, constants and command codes for the cluster chain table engine.
package ccte_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned StepW = AddrW + 1;

  localparam logic [31:0] EndMark = 32'h0FFF_FFFF;
  localparam logic [31:0] NoNext = 32'hFFFF_FFFF;
  localparam logic [31:0] BadMark = 32'h0FFF_FFF7;
  localparam logic [31:0] EndLow = 32'h0FFF_FFF8;
  localparam logic [31:0] NotClus = 32'h1000_0000;
  localparam logic [31:0] FirstClus = 32'h0000_0002;

  typedef enum logic [3:0] {
    REQ_WRITE = 4'd0,
    REQ_READ = 4'd1,
    REQ_SETFREE = 4'd2,
    REQ_CLASSIFY = 4'd3,
    REQ_NTH = 4'd4,
    REQ_RUN = 4'd5,
    REQ_LENGTH = 4'd6,
    REQ_ALLOC = 4'd7,
    REQ_FREE = 4'd8,
    REQ_CUT = 4'd9,
    REQ_INSERT = 4'd10
  } req_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BOUND = 3'd1,
    ST_MEM = 3'd2,
    ST_ADDR = 3'd3,
    ST_WALK = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    KIND_FREE = 3'd0,
    KIND_ALLOC = 3'd1,
    KIND_RSVD = 3'd2,
    KIND_BAD = 3'd3,
    KIND_END = 3'd4,
    KIND_NONE = 3'd5
  } kind_e;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [AddrW-1:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

  function automatic logic is_end(input logic [31:0] v);
    return (v >= EndLow) && (v < NotClus);
  endfunction

  function automatic logic [2:0] kind_of(input logic [31:0] v, input logic [12:0] cc);
    logic [31:0] c;
    c = {19'd0, cc};
    if (v == 32'd0) return KIND_FREE;
    if (v >= FirstClus && v < c) return KIND_ALLOC;
    if (v >= c && v < BadMark) return KIND_RSVD;
    if (v == BadMark) return KIND_BAD;
    if (is_end(v)) return KIND_END;
    return KIND_NONE;
  endfunction

endpackage

@@ src/ccte_table.sv @@
// Table memory: one port, registered read data.
module ccte_table (
  input  logic              clk_i,
  input  ccte_pkg::mem_req_t req_i,
  output logic [31:0]       rdata_o
);
  import ccte_pkg::*;

  logic [31:0] mem [TableDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_o <= mem[req_i.addr];
    end
  end
endmodule

@@ src/ccte_seq.sv @@
// Sequencer: walks chains through the table one read at a time.
module ccte_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [3:0]         req_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  input  logic [12:0]        n_i,
  input  logic [12:0]        cc_i,
  output ccte_pkg::mem_req_t mem_o,
  input  logic [31:0]        rdata_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [31:0]        val_o,
  output logic [12:0]        cnt_o,
  output logic [2:0]         kind_o,
  output logic [2:0]         st_o
);
  import ccte_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WAIT = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_WR1 = 3'd3;
  localparam logic [2:0] S_WR2 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [3:0]  req_q, req_d;
  logic [31:0] a_q, a_d, b_q, b_d, cur_q, cur_d, last_q, last_d, fh_q, fh_d;
  logic [31:0] val_q, val_d, sav_q, sav_d;
  logic [12:0] n_q, n_d, cnt_q, cnt_d, i_q, i_d;
  logic [2:0]  kind_q, kind_d, st_q, st_d;
  logic [StepW-1:0] steps_q, steps_d;

  // Check a counted read at idx against the step limit and the table depth; returns its status.
  function automatic logic [2:0] chk(input logic [31:0] idx, input logic [StepW-1:0] s);
    if (s >= StepW'(TableDepth)) return ST_WALK;
    if (idx >= TableDepth) return ST_ADDR;
    return ST_OK;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fh_q <= EndMark;
    end else begin
      state_q <= state_d;
      fh_q <= fh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; a_q <= a_d; b_q <= b_d; cur_q <= cur_d; last_q <= last_d;
    val_q <= val_d; sav_q <= sav_d; n_q <= n_d; cnt_q <= cnt_d; i_q <= i_d;
    kind_q <= kind_d; st_q <= st_d; steps_q <= steps_d;
  end

  always_comb begin
    logic [2:0]  c;
    logic [31:0] nx;
    state_d = state_q; req_d = req_q; a_d = a_q; b_d = b_q; cur_d = cur_q;
    last_d = last_q; fh_d = fh_q; val_d = val_q; sav_d = sav_q; n_d = n_q;
    cnt_d = cnt_q; i_d = i_q; kind_d = kind_q; st_d = st_q; steps_d = steps_q;
    mem_o = '0;
    c = ST_OK;
    nx = rdata_i;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_i; a_d = a_i; b_d = b_i; n_d = n_i;
          val_d = '0; cnt_d = '0; kind_d = '0; st_d = ST_OK; i_d = '0;
          last_d = '0; steps_d = '0; cur_d = a_i;
          state_d = S_DONE;
          case (req_i)
            REQ_WRITE: begin
              if (a_i >= TableDepth) st_d = ST_ADDR;
              else begin
                mem_o.wr = 1'b1; mem_o.addr = a_i[AddrW-1:0]; mem_o.wdata = b_i;
              end
            end
            REQ_READ, REQ_CUT, REQ_FREE, REQ_RUN: begin
              c = chk(a_i, '0);
              if (c != ST_OK) st_d = c;
              else begin
                mem_o.rd = 1'b1; mem_o.addr = a_i[AddrW-1:0];
                steps_d = StepW'(1); state_d = S_WAIT;
              end
              if (req_i == REQ_RUN) cnt_d = 13'd1;
            end
            REQ_SETFREE: fh_d = a_i;
            REQ_CLASSIFY: kind_d = kind_of(a_i, cc_i);
            REQ_NTH: state_d = S_EVAL;
            REQ_LENGTH: begin
              if (kind_of(a_i, cc_i) == KIND_ALLOC) begin
                cnt_d = 13'd1; state_d = S_EVAL;
              end
            end
            REQ_ALLOC: begin
              if (n_i == '0) val_d = EndMark;
              else begin
                cur_d = fh_q; state_d = S_EVAL;
              end
            end
            REQ_INSERT: begin
              if (a_i >= TableDepth) st_d = ST_ADDR;
              else begin
                cur_d = b_i; state_d = S_EVAL;
              end
            end
            default: ;
          endcase
        end
      end
      // Decide the next read from cur_q (no read result pending).
      S_EVAL: begin
        state_d = S_WAIT;
        c = chk(cur_q, steps_q);
        if ((req_q == REQ_NTH || req_q == REQ_ALLOC) && i_q >= n_q) begin
          state_d = (req_q == REQ_ALLOC) ? S_WR1 : S_DONE;
          val_d = (req_q == REQ_ALLOC) ? fh_q : cur_q;
        end else if ((req_q == REQ_NTH || req_q == REQ_ALLOC) && is_end(cur_q)) begin
          st_d = (req_q == REQ_NTH) ? ST_BOUND : ST_MEM;
          state_d = S_DONE;
        end else if (c != ST_OK) begin
          st_d = c; state_d = S_DONE;
        end else begin
          last_d = cur_q;
          mem_o.rd = 1'b1; mem_o.addr = cur_q[AddrW-1:0];
          steps_d = steps_q + StepW'(1);
        end
      end
      S_WAIT: begin
        state_d = S_DONE;
        case (req_q)
          REQ_READ: val_d = nx;
          REQ_CUT: begin
            val_d = nx;
            mem_o.wr = 1'b1; mem_o.addr = a_q[AddrW-1:0]; mem_o.wdata = EndMark;
          end
          REQ_NTH, REQ_ALLOC: begin
            cur_d = nx; i_d = i_q + 13'd1; state_d = S_EVAL;
          end
          REQ_LENGTH: begin
            cur_d = nx;
            if (kind_of(nx, cc_i) == KIND_ALLOC) begin
              cnt_d = cnt_q + 13'd1; state_d = S_EVAL;
            end
          end
          REQ_RUN: begin
            if (cnt_q < n_q && nx == cur_q + 32'd1) begin
              c = chk(nx, steps_q);
              cur_d = nx; cnt_d = cnt_q + 13'd1;
              if (c != ST_OK) st_d = c;
              else begin
                mem_o.rd = 1'b1; mem_o.addr = nx[AddrW-1:0];
                steps_d = steps_q + StepW'(1); state_d = S_WAIT;
              end
            end else begin
              val_d = (kind_of(nx, cc_i) == KIND_ALLOC) ? nx : NoNext;
            end
          end
          REQ_FREE, REQ_INSERT: begin
            if (is_end(nx)) begin
              last_d = cur_q; state_d = S_WR1;
            end else begin
              c = chk(nx, steps_q);
              cur_d = nx;
              if (c != ST_OK) st_d = c;
              else begin
                mem_o.rd = 1'b1; mem_o.addr = nx[AddrW-1:0];
                steps_d = steps_q + StepW'(1); state_d = S_WAIT;
              end
            end
          end
          default: ;
        endcase
      end
      S_WR1: begin
        state_d = S_DONE;
        case (req_q)
          REQ_ALLOC: begin
            fh_d = cur_q;
            mem_o.wr = 1'b1; mem_o.addr = last_q[AddrW-1:0]; mem_o.wdata = EndMark;
          end
          REQ_FREE: begin
            mem_o.wr = 1'b1; mem_o.addr = last_q[AddrW-1:0]; mem_o.wdata = fh_q;
            fh_d = a_q;
          end
          default: begin
            mem_o.rd = 1'b1; mem_o.addr = a_q[AddrW-1:0]; state_d = S_WR2;
          end
        endcase
      end
      S_WR2: begin
        mem_o.wr = 1'b1; mem_o.addr = last_q[AddrW-1:0]; mem_o.wdata = nx;
        sav_d = nx;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (req_q == REQ_INSERT && st_q == ST_OK) begin
          mem_o.wr = 1'b1; mem_o.addr = a_q[AddrW-1:0]; mem_o.wdata = b_q;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;
  assign st_o = st_q;
  assign val_o = (st_q != ST_OK) ? '0 : val_q;
  assign cnt_o = (st_q != ST_OK) ? '0 : cnt_q;
  assign kind_o = (st_q != ST_OK) ? '0 : kind_q;
endmodule

@@ src/cluster_chain_table_engine.sv @@
// Top level: stream wrapper, config register and output register of the engine.
//   channel | dir | fields (low bit up)
//   s_axis  | in  | tdata: req_type, cluster_a, cluster_b, count_in (88 bits)
//   m_axis  | out | tdata: value_out, count_out, cluster_kind, status (56 bits)
//   cfg     | in  | cluster_count (13 bits)
// Read, cut, free and run fetch one table entry per cycle; nth, length and alloc pass
// each entry through the eval state before its read, and insert only its first entry.
// Commands without a table walk go straight from idle to the done state, which loads the output register.
// Reset clears the free head to the end mark and cluster_count to 4096.
// The next word is taken only after the result word has left the output register.
module cluster_chain_table_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // req_type, cluster_a, cluster_b, count_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // value_out, count_out, cluster_kind, status
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i
);
  import ccte_pkg::*;

  logic [12:0] cc_q;
  logic        ov_q;
  logic [55:0] od_q;
  mem_req_t    mem;
  logic [31:0] rdata, val;
  logic [12:0] cnt;
  logic [2:0]  kind, st;
  logic        busy, done, start;

  assign s_axis_tready = rst_ni && !busy && !ov_q;
  assign start = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= 13'd4096;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) cc_q <= cfg_wdata_i;
      if (done) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) od_q <= {5'd0, st, kind, cnt, val};
  end

  ccte_table u_table (.clk_i, .req_i(mem), .rdata_o(rdata));

  ccte_seq u_seq (
    .clk_i, .rst_ni, .start_i(start),
    .req_i(s_axis_tdata[3:0]), .a_i(s_axis_tdata[35:4]),
    .b_i(s_axis_tdata[67:36]), .n_i(s_axis_tdata[80:68]), .cc_i(cc_q),
    .mem_o(mem), .rdata_i(rdata), .busy_o(busy), .done_o(done),
    .val_o(val), .cnt_o(cnt), .kind_o(kind), .st_o(st)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("accept while busy");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> m_axis_tvalid) else $error("result lost");
  a_no_rdwr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem.rd && mem.wr)) else $error("port conflict");
endmodule
